[rtl/core/fpa_pkg.sv]
package fpa_pkg;

  // Default numeric format.
  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  // Partial remainder width of the divider cells: the divisor magnitude
  // is at most 2^31, so the shifted remainder needs one bit more.
  localparam int REM_W = 33;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } fpa_op_t;

  // Transaction context that travels alongside the divider chain.
  typedef struct packed {
    fpa_op_t            op;
    logic signed [31:0] res;
    logic               cmp;
    logic [1:0]         st;
    logic               neg;
    logic [31:0]        den;
    logic [63:0]        prod;
  } fpa_side_t;

endpackage

[rtl/core/fpa_div_cell.sv]
module fpa_div_cell #(
  parameter int NUM_W = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [fpa_pkg::REM_W-1:0]     rem_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [NUM_W-1:0]              quo_i,
  input  fpa_pkg::fpa_side_t            side_i,
  output logic                          vld_o,
  output logic [fpa_pkg::REM_W-1:0]     rem_o,
  output logic [NUM_W-1:0]              num_o,
  output logic [NUM_W-1:0]              quo_o,
  output fpa_pkg::fpa_side_t            side_o
);
  import fpa_pkg::*;

  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] den_ext;
  logic             ge;
  logic             vld_r;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  fpa_side_t        side_r;

  // One restoring division step: bring down the next numerator bit.
  assign trial   = {rem_i[REM_W-2:0], num_i[NUM_W-1]};
  assign den_ext = {1'b0, side_i.den};
  assign ge      = (trial >= den_ext);
  assign rem_nxt = ge ? (trial - den_ext) : trial;
  assign num_nxt = {num_i[NUM_W-2:0], 1'b0};
  assign quo_nxt = {quo_i[NUM_W-2:0], ge};

  // Valid bit of this stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // Payload of this stage.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      quo_r  <= quo_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

[rtl/core/fixed_point_alu.sv]
// Channel  | Direction | Ports
// input    | in        | in_valid, in_ready, in_kind, in_operand_a, in_operand_b
// result   | out       | out_valid, out_ready, out_result, out_compare_true, out_status
//
// One transaction is accepted per cycle while the output is not stalled. Each
// result passes the front stage, the row of W+FRAC_BITS divider cells
// (W = min(WORD_BITS, 32)) and the output register.
// A stalled output register freezes the whole pipeline; in_ready follows it.
// Reset clears every stage's valid bit.
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_kind,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result,
  output logic               out_compare_true,
  output logic [1:0]         out_status
);
  import fpa_pkg::*;

  localparam int W     = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int NUM_W = W + FRAC_BITS;
  localparam logic signed [63:0] WMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  function automatic sat_t fpa_sat(input logic signed [63:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = 32'(v);
    if (v > WMAX) begin
      s.val = 32'(WMAX);
      s.ovf = 1'b1;
    end else if (v < WMIN) begin
      s.val = 32'(WMIN);
      s.ovf = 1'b1;
    end
    return s;
  endfunction

  logic               en;
  logic signed [31:0] sa, sb;
  logic [31:0]        mag_a, mag_b;
  fpa_op_t            op;
  fpa_side_t          side_nxt;
  sat_t               sat_v;
  logic               va_r;
  fpa_side_t          side_a_r;
  logic [NUM_W-1:0]   num_a_r, num_nxt;

  logic               vld_c  [0:NUM_W];
  logic [REM_W-1:0]   rem_c  [0:NUM_W];
  logic [NUM_W-1:0]   num_c  [0:NUM_W];
  logic [NUM_W-1:0]   quo_c  [0:NUM_W];
  fpa_side_t          side_c [0:NUM_W];

  fpa_side_t          fin;
  logic [REM_W:0]     rem_dbl;
  logic               rnd_up;
  logic [NUM_W:0]     q_div;
  logic [63:0]        q_mul, q_mag, lim;
  logic signed [31:0] res_nxt;
  logic [1:0]         st_nxt;

  logic               out_valid_r;
  logic signed [31:0] out_result_r;
  logic               out_cmp_r;
  logic [1:0]         out_status_r;

  // The pipeline moves whenever the output register is free or drained.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Operands narrowed to the working word and sign-extended.
  assign sa    = (in_operand_a <<< (32 - W)) >>> (32 - W);
  assign sb    = (in_operand_b <<< (32 - W)) >>> (32 - W);
  assign mag_a = sa[31] ? 32'(-sa) : 32'(sa);
  assign mag_b = sb[31] ? 32'(-sb) : 32'(sb);
  assign op    = fpa_op_t'(in_kind);
  assign num_nxt = NUM_W'(mag_a[W-1:0]) << FRAC_BITS;

  // Front stage: add/sub, increment/decrement, conversions, comparisons and min/max, multiplier and divider set-up.
  always_comb begin
    side_nxt      = '0;
    side_nxt.op   = op;
    side_nxt.neg  = sa[31] ^ sb[31];
    side_nxt.den  = mag_b;
    side_nxt.prod = 64'(mag_a) * 64'(mag_b);
    sat_v         = '0;
    case (op)
      OP_ADD:      sat_v = fpa_sat(64'(sa) + 64'(sb));
      OP_SUB:      sat_v = fpa_sat(64'(sa) - 64'(sb));
      OP_INC:      sat_v = fpa_sat(64'(sa) + 64'sd1);
      OP_DEC:      sat_v = fpa_sat(64'(sa) - 64'sd1);
      OP_FROM_INT: sat_v = fpa_sat(64'(sa) <<< FRAC_BITS);
      default:     sat_v = '0;
    endcase
    case (op)
      OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_FROM_INT: begin
        side_nxt.res = sat_v.val;
        side_nxt.st  = sat_v.ovf ? ST_OVF : ST_OK;
      end
      OP_DIV:    side_nxt.st  = (sb == 32'sd0) ? ST_DIV0 : ST_OK;
      OP_GT:     side_nxt.cmp = (sa > sb);
      OP_LT:     side_nxt.cmp = (sa < sb);
      OP_GE:     side_nxt.cmp = (sa >= sb);
      OP_LE:     side_nxt.cmp = (sa <= sb);
      OP_EQ:     side_nxt.cmp = (sa == sb);
      OP_NE:     side_nxt.cmp = (sa != sb);
      OP_MIN:    side_nxt.res = (sa < sb) ? sa : sb;
      OP_MAX:    side_nxt.res = (sa > sb) ? sa : sb;
      OP_TO_INT: side_nxt.res = sa >>> FRAC_BITS;
      default:   side_nxt.res = 32'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a_r <= side_nxt;
      num_a_r  <= num_nxt;
    end
  end

  // Row of divider cells, one quotient bit per cell.
  assign vld_c[0]  = va_r;
  assign rem_c[0]  = '0;
  assign num_c[0]  = num_a_r;
  assign quo_c[0]  = '0;
  assign side_c[0] = side_a_r;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_div_cell #(.NUM_W(NUM_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld_c[i]),
      .rem_i  (rem_c[i]),
      .num_i  (num_c[i]),
      .quo_i  (quo_c[i]),
      .side_i (side_c[i]),
      .vld_o  (vld_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .num_o  (num_c[i+1]),
      .quo_o  (quo_c[i+1]),
      .side_o (side_c[i+1])
    );
  end

  // Back stage: rounding, saturation and sign for product and quotient.
  assign fin     = side_c[NUM_W];
  assign rem_dbl = {rem_c[NUM_W], 1'b0};
  assign rnd_up  = (rem_dbl >= (REM_W + 1)'(fin.den));
  assign q_div   = (NUM_W + 1)'(quo_c[NUM_W]) + (NUM_W + 1)'(rnd_up);
  assign q_mul   = (fin.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign q_mag   = (fin.op == OP_MUL) ? q_mul : 64'(q_div);
  assign lim     = fin.neg ? 64'(WMAX) + 64'd1 : 64'(WMAX);

  always_comb begin
    res_nxt = fin.res;
    st_nxt  = fin.st;
    if (fin.op == OP_MUL || (fin.op == OP_DIV && fin.st != ST_DIV0)) begin
      if (q_mag > lim) begin
        res_nxt = fin.neg ? 32'(WMIN) : 32'(WMAX);
        st_nxt  = ST_OVF;
      end else begin
        res_nxt = fin.neg ? -$signed(q_mag[31:0]) : $signed(q_mag[31:0]);
        st_nxt  = ST_OK;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_c[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= res_nxt;
      out_cmp_r    <= fin.cmp;
      out_status_r <= st_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_compare_true = out_cmp_r;
  assign out_status       = out_status_r;

endmodule

[rtl/core/fpa_chk.sv]
module fpa_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_result,
  input logic               out_compare_true,
  input logic [1:0]         out_status
);
  import fpa_pkg::*;

  // A stalled result transaction holds its result and status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_status))
    else $error("stalled result changed");

  // Status never carries an undefined code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // A true comparison comes with a zero result and a clean status.
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result == 32'sd0 && out_status == ST_OK)
    else $error("comparison result not clean");

  // Division by zero returns zero.
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIV0 |-> out_result == 32'sd0 && !out_compare_true)
    else $error("divide by zero result not zero");

  // Input is refused while a result is stalled.
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind fixed_point_alu fpa_chk u_fpa_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result       (out_result),
  .out_compare_true (out_compare_true),
  .out_status       (out_status)
);
